// ===== rtl/ppm_frame_decoder_unit_assert.svh =====
// assertion macros used by the decoder rtl
`ifndef PPM_FRAME_DECODER_UNIT_ASSERT_SVH
`define PPM_FRAME_DECODER_UNIT_ASSERT_SVH

// checked on every clock edge outside reset
`define PFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define PFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppm_fdu_pkg.sv =====
// package with types and constants of the ppm frame decoder
`timescale 1ns / 1ps
`default_nettype none

package ppm_fdu_pkg;

    localparam int CHANNEL_COUNT = 11;
    localparam int LOCK_PULSES   = 3;

    localparam int CH_AW     = $clog2(CHANNEL_COUNT);
    localparam int SLOT_W    = $clog2(CHANNEL_COUNT + LOCK_PULSES + 1);
    localparam int COUNT_W   = 4;
    localparam int TIME_W    = 16;
    localparam int WIDTH_W   = 16;
    localparam int VALUE_W   = 15;
    localparam int CHAN_W    = 8;
    localparam int OP_W      = 3;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [TIME_W-1:0]  SYNC_THR_RESET  = 16'd3000;
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd900;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2100;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET     = 16'd1500;

    localparam logic [VALUE_W-1:0] FAILSAFE_LOW = 15'd900;
    localparam logic [VALUE_W-1:0] FAILSAFE_MID = 15'd1500;
    localparam logic [VALUE_W-1:0] VALUE_MAX    = 15'd32767;
    localparam logic [CHAN_W-1:0]  LOW_CHANNEL  = 8'd2;

    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(CHANNEL_COUNT + LOCK_PULSES);
    localparam logic [SLOT_W-1:0] SLOT_FULL  = SLOT_W'(CHANNEL_COUNT);

    typedef enum logic [OP_W-1:0] {
        OP_EDGE    = 3'd0,
        OP_READ    = 3'd1,
        OP_SET_OVR = 3'd2,
        OP_CLR_OVR = 3'd3,
        OP_POLL    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_SYNC_THR  = 2'd0,
        REG_MIN_WIDTH = 2'd1,
        REG_MAX_WIDTH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  sync_threshold;
        logic [WIDTH_W-1:0] min_width;
        logic [WIDTH_W-1:0] max_width;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [CH_AW-1:0]   waddr;
        logic [WIDTH_W-1:0] wdata;
        logic               re;
        logic [CH_AW-1:0]   raddr;
    } width_req_t;

    typedef struct packed {
        logic               we;
        logic [CH_AW-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [CH_AW-1:0]   raddr;
    } ovr_req_t;

    typedef struct packed {
        logic               is_read;
        logic               ch_ok;
        logic               ch_low;
        logic               w_vld;
        logic               o_vld;
        logic [COUNT_W-1:0] frame_channels;
        logic               new_frame;
        logic               accepted;
        logic               in_sync;
    } info_t;

endpackage

`default_nettype wire

// ===== rtl/ppm_fdu_ram.sv =====
// generic single write port, single read port synchronous ram
`timescale 1ns / 1ps
`default_nettype none

module ppm_fdu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 11
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppm_fdu_regs.sv =====
// apb configuration registers of the decoder
`timescale 1ns / 1ps
`default_nettype none

module ppm_fdu_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ppm_fdu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ppm_fdu_pkg::PDATA_W-1:0] pwdata,
    output      logic [ppm_fdu_pkg::PDATA_W-1:0] prdata,
    output      ppm_fdu_pkg::cfg_t               cfg
);

    ppm_fdu_pkg::cfg_t     cfg_reg;
    ppm_fdu_pkg::cfg_t     cfg_next;
    ppm_fdu_pkg::reg_idx_t idx;

    assign idx = ppm_fdu_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (idx)
            ppm_fdu_pkg::REG_SYNC_THR:
            begin
                prdata = ppm_fdu_pkg::PDATA_W'(cfg_reg.sync_threshold);
                if (psel && penable && pwrite)
                begin
                    cfg_next.sync_threshold = pwdata[15:0];
                end
            end
            ppm_fdu_pkg::REG_MIN_WIDTH:
            begin
                prdata = ppm_fdu_pkg::PDATA_W'(cfg_reg.min_width);
                if (psel && penable && pwrite)
                begin
                    cfg_next.min_width = pwdata[15:0];
                end
            end
            ppm_fdu_pkg::REG_MAX_WIDTH:
            begin
                prdata = ppm_fdu_pkg::PDATA_W'(cfg_reg.max_width);
                if (psel && penable && pwrite)
                begin
                    cfg_next.max_width = pwdata[15:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_threshold <= ppm_fdu_pkg::SYNC_THR_RESET;
            cfg_reg.min_width      <= ppm_fdu_pkg::MIN_WIDTH_RESET;
            cfg_reg.max_width      <= ppm_fdu_pkg::MAX_WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/ppm_fdu_ctrl.sv =====
// frame state, valid bits and memory requests of the decoder
`timescale 1ns / 1ps
`default_nettype none

module ppm_fdu_ctrl (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  fire,
    input  wire logic [ppm_fdu_pkg::OP_W-1:0]          op,
    input  wire logic [ppm_fdu_pkg::TIME_W-1:0]        edge_time,
    input  wire logic [ppm_fdu_pkg::CHAN_W-1:0]        channel,
    input  wire logic signed [ppm_fdu_pkg::WIDTH_W-1:0] override_value,
    input  wire ppm_fdu_pkg::cfg_t                     cfg,
    output      ppm_fdu_pkg::width_req_t               width_req,
    output      ppm_fdu_pkg::ovr_req_t                 ovr_req,
    output      ppm_fdu_pkg::info_t                    info
);

    logic [ppm_fdu_pkg::TIME_W-1:0]        prev_edge_reg;
    logic [ppm_fdu_pkg::TIME_W-1:0]        prev_edge_next;
    logic [ppm_fdu_pkg::SLOT_W-1:0]        slot_reg;
    logic [ppm_fdu_pkg::SLOT_W-1:0]        slot_next;
    logic [ppm_fdu_pkg::COUNT_W-1:0]       count_reg;
    logic [ppm_fdu_pkg::COUNT_W-1:0]       count_next;
    logic                                  flag_reg;
    logic                                  flag_next;
    logic [ppm_fdu_pkg::CHANNEL_COUNT-1:0] wvld_reg;
    logic [ppm_fdu_pkg::CHANNEL_COUNT-1:0] wvld_next;
    logic [ppm_fdu_pkg::CHANNEL_COUNT-1:0] ovld_reg;
    logic [ppm_fdu_pkg::CHANNEL_COUNT-1:0] ovld_next;

    logic [ppm_fdu_pkg::TIME_W-1:0]  gap;
    logic [ppm_fdu_pkg::WIDTH_W-1:0] clamped;
    logic [ppm_fdu_pkg::CH_AW-1:0]   ch_idx;
    logic [ppm_fdu_pkg::CH_AW-1:0]   slot_idx;
    logic                            locked;
    logic                            ch_in;
    logic                            ovr_neg;

    assign gap      = edge_time - prev_edge_reg;
    assign locked   = slot_reg <= ppm_fdu_pkg::SLOT_FULL;
    assign ch_in    = channel < ppm_fdu_pkg::CHAN_W'(ppm_fdu_pkg::CHANNEL_COUNT);
    assign ch_idx   = channel[ppm_fdu_pkg::CH_AW-1:0];
    assign slot_idx = slot_reg[ppm_fdu_pkg::CH_AW-1:0];
    assign ovr_neg  = override_value[ppm_fdu_pkg::WIDTH_W-1];

    // when the clamp limits cross, a gap below min gives min and any other gap gives max
    always_comb
    begin
        if (gap < cfg.min_width)
        begin
            clamped = cfg.min_width;
        end
        else if (gap > cfg.max_width)
        begin
            clamped = cfg.max_width;
        end
        else
        begin
            clamped = gap;
        end
    end

    always_comb
    begin
        prev_edge_next = prev_edge_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        wvld_next      = wvld_reg;
        ovld_next      = ovld_reg;

        width_req.we    = 1'b0;
        width_req.waddr = slot_idx;
        width_req.wdata = clamped;
        width_req.re    = 1'b0;
        width_req.raddr = ch_idx;
        ovr_req.we      = 1'b0;
        ovr_req.waddr   = ch_idx;
        ovr_req.wdata   = override_value[ppm_fdu_pkg::VALUE_W-1:0];
        ovr_req.re      = 1'b0;
        ovr_req.raddr   = ch_idx;

        info.is_read   = 1'b0;
        info.ch_ok     = locked && ch_in;
        info.ch_low    = channel == ppm_fdu_pkg::LOW_CHANNEL;
        info.w_vld     = 1'b0;
        info.o_vld     = 1'b0;
        info.new_frame = 1'b0;
        info.accepted  = 1'b0;

        if (fire)
        begin
            unique case (ppm_fdu_pkg::op_t'(op))
                ppm_fdu_pkg::OP_EDGE:
                begin
                    prev_edge_next = edge_time;
                    if (gap < cfg.sync_threshold)
                    begin
                        if (slot_reg < ppm_fdu_pkg::SLOT_FULL)
                        begin
                            width_req.we        = 1'b1;
                            wvld_next[slot_idx] = 1'b1;
                            slot_next           = slot_reg + ppm_fdu_pkg::SLOT_W'(1);
                        end
                    end
                    else if (locked)
                    begin
                        count_next = ppm_fdu_pkg::COUNT_W'(slot_reg);
                        flag_next  = 1'b1;
                        slot_next  = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg - ppm_fdu_pkg::SLOT_W'(1);
                    end
                end
                ppm_fdu_pkg::OP_READ:
                begin
                    info.is_read = 1'b1;
                    if (locked && ch_in)
                    begin
                        width_req.re = 1'b1;
                        ovr_req.re   = 1'b1;
                        info.w_vld   = wvld_reg[ch_idx];
                        info.o_vld   = ovld_reg[ch_idx];
                    end
                end
                ppm_fdu_pkg::OP_SET_OVR:
                begin
                    if (ch_in && !ovr_neg)
                    begin
                        ovr_req.we        = 1'b1;
                        ovld_next[ch_idx] = 1'b1;
                        info.accepted     = override_value != '0;
                    end
                end
                ppm_fdu_pkg::OP_CLR_OVR:
                begin
                    ovld_next = '0;
                end
                ppm_fdu_pkg::OP_POLL:
                begin
                    if (locked)
                    begin
                        info.new_frame = flag_reg;
                        flag_next      = 1'b0;
                    end
                end
                default:
                begin
                    prev_edge_next = prev_edge_reg;
                end
            endcase
        end

        info.in_sync        = slot_next <= ppm_fdu_pkg::SLOT_FULL;
        info.frame_channels = info.in_sync ? count_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg <= '0;
            slot_reg      <= ppm_fdu_pkg::SLOT_RESET;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            wvld_reg      <= '0;
            ovld_reg      <= '0;
        end
        else
        begin
            prev_edge_reg <= prev_edge_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            wvld_reg      <= wvld_next;
            ovld_reg      <= ovld_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppm_fdu_out.sv =====
// read stage and output register of the decoder
`timescale 1ns / 1ps
`default_nettype none

`include "ppm_frame_decoder_unit_assert.svh"

module ppm_fdu_out (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire ppm_fdu_pkg::info_t                info,
    input  wire logic [ppm_fdu_pkg::WIDTH_W-1:0]   width_rdata,
    input  wire logic [ppm_fdu_pkg::VALUE_W-1:0]   ovr_rdata,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [ppm_fdu_pkg::VALUE_W-1:0]   value,
    output      logic [ppm_fdu_pkg::COUNT_W-1:0]   frame_channels,
    output      logic                              new_frame,
    output      logic                              accepted,
    output      logic                              in_sync
);

    logic                            s1_valid_reg;
    ppm_fdu_pkg::info_t              s1_reg;
    logic                            out_valid_reg;
    logic [ppm_fdu_pkg::VALUE_W-1:0] value_reg;
    logic [ppm_fdu_pkg::COUNT_W-1:0] frame_channels_reg;
    logic                            new_frame_reg;
    logic                            accepted_reg;
    logic                            in_sync_reg;

    logic                            s1_adv;
    logic [ppm_fdu_pkg::WIDTH_W-1:0] width_eff;
    logic [ppm_fdu_pkg::VALUE_W-1:0] value_next;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign width_eff = s1_reg.w_vld ? width_rdata : ppm_fdu_pkg::WIDTH_RESET;

    always_comb
    begin
        priority if (!s1_reg.is_read)
        begin
            value_next = '0;
        end
        else if (!s1_reg.ch_ok)
        begin
            value_next = s1_reg.ch_low ? ppm_fdu_pkg::FAILSAFE_LOW
                                       : ppm_fdu_pkg::FAILSAFE_MID;
        end
        else if (s1_reg.o_vld && ovr_rdata != '0)
        begin
            value_next = ovr_rdata;
        end
        else if (width_eff[ppm_fdu_pkg::WIDTH_W-1])
        begin
            value_next = ppm_fdu_pkg::VALUE_MAX;
        end
        else
        begin
            value_next = width_eff[ppm_fdu_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_reg <= info;
        end
        if (s1_adv)
        begin
            value_reg          <= value_next;
            frame_channels_reg <= s1_reg.frame_channels;
            new_frame_reg      <= s1_reg.new_frame;
            accepted_reg       <= s1_reg.accepted;
            in_sync_reg        <= s1_reg.in_sync;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign frame_channels = frame_channels_reg;
    assign new_frame      = new_frame_reg;
    assign accepted       = accepted_reg;
    assign in_sync        = in_sync_reg;

    `PFD_ASSERT(a_stall_blocks_input, (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready, "input taken while both stages are full and stalled")
    `PFD_ASSERT(a_advance_fills_output, s1_adv |=> out_valid_reg, "advanced item did not reach the output register")
    `PFD_ASSERT(a_no_count_out_of_sync, (out_valid_reg && !in_sync_reg) |-> (frame_channels_reg == '0), "channel count shown while out of sync")
    `PFD_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> (!s1_valid_reg && !out_valid_reg), "pipeline holds an item as reset ends")

endmodule

`default_nettype wire

// ===== rtl/ppm_frame_decoder_unit.sv =====
// top level of the ppm frame decoder
//
//  channel   signals                                   direction
//  in        in_valid/in_ready, op, edge_time,         to block
//            channel, override_value
//  out       out_valid/out_ready, value,               from block
//            frame_channels, new_frame, accepted, in_sync
//  cfg       psel, penable, pwrite, paddr, pwdata,     both
//            prdata, pready
//
//  one item per cycle while the output is not stalled; a taken item passes the read stage
//  (state update and memory read), then the output register
//  widths and overrides sit in two synchronous rams; writes land at acceptance,
//  so the next item's read already sees them
//  reset needs no clearing pass: per-entry valid bits select the reset values
//  a stalled output holds one result and one item in the read stage
`timescale 1ns / 1ps
`default_nettype none

module ppm_frame_decoder_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output      logic                                   in_ready,
    input  wire logic [ppm_fdu_pkg::OP_W-1:0]           op,
    input  wire logic [ppm_fdu_pkg::TIME_W-1:0]         edge_time,
    input  wire logic [ppm_fdu_pkg::CHAN_W-1:0]         channel,
    input  wire logic signed [ppm_fdu_pkg::WIDTH_W-1:0] override_value,
    output      logic                                   out_valid,
    input  wire logic                                   out_ready,
    output      logic [ppm_fdu_pkg::VALUE_W-1:0]        value,
    output      logic [ppm_fdu_pkg::COUNT_W-1:0]        frame_channels,
    output      logic                                   new_frame,
    output      logic                                   accepted,
    output      logic                                   in_sync,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ppm_fdu_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [ppm_fdu_pkg::PDATA_W-1:0]        pwdata,
    output      logic [ppm_fdu_pkg::PDATA_W-1:0]        prdata,
    output      logic                                   pready
);

    ppm_fdu_pkg::cfg_t               cfg;
    ppm_fdu_pkg::width_req_t         width_req;
    ppm_fdu_pkg::ovr_req_t           ovr_req;
    ppm_fdu_pkg::info_t              info;
    logic [ppm_fdu_pkg::WIDTH_W-1:0] width_rdata;
    logic [ppm_fdu_pkg::VALUE_W-1:0] ovr_rdata;
    logic                            in_fire;

    assign pready  = 1'b1;
    assign in_fire = in_valid && in_ready;

    ppm_fdu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ppm_fdu_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (in_fire),
        .op             (op),
        .edge_time      (edge_time),
        .channel        (channel),
        .override_value (override_value),
        .cfg            (cfg),
        .width_req      (width_req),
        .ovr_req        (ovr_req),
        .info           (info)
    );

    ppm_fdu_ram #(
        .WIDTH (ppm_fdu_pkg::WIDTH_W),
        .DEPTH (ppm_fdu_pkg::CHANNEL_COUNT)
    ) u_width_ram (
        .clk   (clk),
        .we    (width_req.we),
        .waddr (width_req.waddr),
        .wdata (width_req.wdata),
        .re    (width_req.re),
        .raddr (width_req.raddr),
        .rdata (width_rdata)
    );

    ppm_fdu_ram #(
        .WIDTH (ppm_fdu_pkg::VALUE_W),
        .DEPTH (ppm_fdu_pkg::CHANNEL_COUNT)
    ) u_ovr_ram (
        .clk   (clk),
        .we    (ovr_req.we),
        .waddr (ovr_req.waddr),
        .wdata (ovr_req.wdata),
        .re    (ovr_req.re),
        .raddr (ovr_req.raddr),
        .rdata (ovr_rdata)
    );

    ppm_fdu_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .info           (info),
        .width_rdata    (width_rdata),
        .ovr_rdata      (ovr_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .frame_channels (frame_channels),
        .new_frame      (new_frame),
        .accepted       (accepted),
        .in_sync        (in_sync)
    );

endmodule

`default_nettype wire
